@@ design/assert_macros.svh @@
// Assertion macros shared by the line breaker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ design/glj_pkg.sv @@
// Types, constants and helpers of the greedy line breaker.
package glj_pkg;

    localparam int MAX_LINE_BOXES = 32;
    localparam int SLOT_W = $clog2(MAX_LINE_BOXES);
    localparam int FILL_W = SLOT_W + 1;
    // total weight over the non-last boxes of a line
    localparam int TW = 16 + SLOT_W;
    // dividend 2*mag*w + total stays below 2^50
    localparam int DW = 50;
    localparam int DCW = $clog2(DW);
    localparam int ADDR_W = SLOT_W + 1;
    // position, penalty, glue, shrink, stretch
    localparam int MEM_W = 16 + 32 + 32 + 16 + 16;

    // register indexes
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_MAX_PEN    = 2'd1;
    localparam logic [1:0] CFG_JMODE      = 2'd2;

    // justification modes
    localparam logic [1:0] JM_FULL   = 2'd0;
    localparam logic [1:0] JM_ALL    = 2'd1;
    localparam logic [1:0] JM_CENTRE = 2'd2;
    localparam logic [1:0] JM_LEFT   = 2'd3;

    typedef enum logic [1:0] {
        K_JUST,
        K_CENTRE,
        K_LEFT
    } kind_t;

    // one line handed from front to back
    typedef struct packed {
        logic               bank;
        logic [FILL_W-1:0]  fill;
        kind_t              kind;
        logic               broke;
        logic signed [32:0] leftover;
        logic [TW-1:0]      total;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [MEM_W-1:0]  data;
    } memwr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_DIV,
        B_FIN,
        B_OUT
    } bstate_t;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sh007FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -36'sh0080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/greedy_line_breaker_justify_top.sv @@
// Top level of the greedy line breaker with justification.
//  channel | handshake           | payload
//  input   | s_valid / s_ready   | s_mode, s_box_width, s_ideal_glue, weights, s_break_cost
//  result  | m_valid / m_ready   | m_box_position .. m_line_end, one word per box
//  config  | cfg_we              | cfg_index, cfg_wdata
// A word that joins a line is accepted without a stall; lines go to the back through a queue.
// Each result goes through the read, multiply, set and hand-over states, plus the idle state
// at the start of a line and the divide state for a justified non-last box with a nonzero
// weight total; the divider is a one-bit-per-cycle restoring divider.
// Two line banks: the front stalls only when a line must be handed over while the
// other bank is still being read out. Synchronous active-low reset clears all control.
module greedy_line_breaker_justify_top import glj_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_mode,
    input  logic [31:0]  s_box_width,
    input  logic [31:0]  s_ideal_glue,
    input  logic [15:0]  s_stretch_weight,
    input  logic [15:0]  s_shrink_weight,
    input  logic signed [31:0] s_break_cost,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [15:0]  m_box_position,
    output logic signed [31:0] m_glue_after,
    output logic signed [31:0] m_pad_before,
    output logic         m_broke_after,
    output logic signed [31:0] m_box_penalty,
    output logic         m_line_end
);

    memwr_t mem_wr;
    cmd_t   push_data, pop_data;
    logic   push, pop, full, empty;
    done_t  done;

    glj_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_box_width     (s_box_width),
        .s_ideal_glue    (s_ideal_glue),
        .s_stretch_weight(s_stretch_weight),
        .s_shrink_weight (s_shrink_weight),
        .s_break_cost    (s_break_cost),
        .mem_wr          (mem_wr),
        .cmd_push        (push),
        .cmd_data        (push_data),
        .cmd_full        (full),
        .done            (done)
    );

    glj_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .pop_data (pop_data),
        .full     (full),
        .empty    (empty)
    );

    glj_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mem_wr        (mem_wr),
        .cmd_in        (pop_data),
        .cmd_empty     (empty),
        .cmd_pop       (pop),
        .done          (done),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_box_position(m_box_position),
        .m_glue_after  (m_glue_after),
        .m_pad_before  (m_pad_before),
        .m_broke_after (m_broke_after),
        .m_box_penalty (m_box_penalty),
        .m_line_end    (m_line_end)
    );

endmodule

@@ design/glj_cmd_fifo.sv @@
// Two-entry queue of line commands between front and back.
module glj_cmd_fifo import glj_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t pop_data,
    output logic full,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/glj_front.sv @@
// Front: takes words, packs the line, hands finished lines to the back.
`include "assert_macros.svh"
module glj_front import glj_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_mode,
    input  logic [31:0]  s_box_width,
    input  logic [31:0]  s_ideal_glue,
    input  logic [15:0]  s_stretch_weight,
    input  logic [15:0]  s_shrink_weight,
    input  logic signed [31:0] s_break_cost,
    output memwr_t       mem_wr,
    output logic         cmd_push,
    output cmd_t         cmd_data,
    input  logic         cmd_full,
    input  done_t        done
);

    logic [31:0]        line_width_reg;
    logic signed [31:0] max_pen_reg;
    logic [1:0]         jmode_reg;
    logic [31:0]        used_reg, used_next;
    logic [31:0]        pend_reg, pend_next;
    logic               latch_reg, latch_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic               bank_reg, bank_next;
    logic [1:0]         busy_reg, busy_next;
    logic [TW-1:0]      sum_st_reg, sum_st_next;
    logic [TW-1:0]      sum_sh_reg, sum_sh_next;
    logic [15:0]        prev_st_reg, prev_sh_reg;

    logic [33:0]        sum34;
    logic               fits, empty_line, join_box, brk, need_push, acc;
    logic signed [32:0] leftover;
    logic [SLOT_W-1:0]  slot;
    kind_t              kind;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= 32'd0;
            max_pen_reg    <= 32'sd0;
            jmode_reg      <= JM_FULL;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_wdata;
                CFG_MAX_PEN:    max_pen_reg    <= $signed(cfg_wdata);
                CFG_JMODE:      jmode_reg      <= cfg_wdata[1:0];
                default:        ;
            endcase
        end
    end

    // classify the word
    always_comb begin
        sum34      = {2'b0, used_reg} + {2'b0, pend_reg} + {2'b0, s_box_width};
        fits       = sum34 <= {2'b0, line_width_reg};
        empty_line = (fill_reg == '0);
        join_box   = !empty_line && (latch_reg || fits)
                     && (fill_reg < FILL_W'(MAX_LINE_BOXES));
        brk        = !empty_line && !join_box;
        need_push  = s_valid && (s_mode ? !empty_line : brk);
        s_ready    = !need_push || (!busy_reg[~bank_reg] && !cmd_full);
        acc        = s_valid && s_ready;
        leftover   = $signed({1'b0, line_width_reg}) - $signed({1'b0, used_reg});
        slot       = join_box ? fill_reg[SLOT_W-1:0] : '0;
    end

    // line setting for the line being handed over
    always_comb begin
        if (s_mode) begin
            unique case (jmode_reg)
                JM_FULL:   kind = K_LEFT;
                JM_ALL:    kind = K_JUST;
                JM_CENTRE: kind = K_CENTRE;
                default:   kind = K_LEFT;
            endcase
        end else begin
            unique case (jmode_reg)
                JM_CENTRE: kind = K_CENTRE;
                JM_LEFT:   kind = K_LEFT;
                default:   kind = K_JUST;
            endcase
        end
    end

    always_comb begin
        cmd_push          = acc && need_push;
        cmd_data.bank     = bank_reg;
        cmd_data.fill     = fill_reg;
        cmd_data.kind     = kind;
        cmd_data.broke    = !s_mode;
        cmd_data.leftover = leftover;
        cmd_data.total    = leftover[32] ? sum_sh_reg : sum_st_reg;
        mem_wr.en         = acc && !s_mode;
        mem_wr.addr       = {(brk ? ~bank_reg : bank_reg), slot};
        mem_wr.data       = {cnt_reg, s_break_cost, s_ideal_glue,
                             s_shrink_weight, s_stretch_weight};
    end

    // packing state
    always_comb begin
        used_next   = used_reg;
        pend_next   = pend_reg;
        latch_next  = latch_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        bank_next   = bank_reg ^ cmd_push;
        sum_st_next = sum_st_reg;
        sum_sh_next = sum_sh_reg;
        busy_next   = busy_reg;
        if (done.valid) begin
            busy_next[done.bank] = 1'b0;
        end
        if (cmd_push) begin
            busy_next[bank_reg] = 1'b1;
        end
        if (acc) begin
            if (s_mode) begin
                used_next   = '0;
                pend_next   = '0;
                latch_next  = 1'b0;
                fill_next   = '0;
                cnt_next    = '0;
                sum_st_next = '0;
                sum_sh_next = '0;
            end else begin
                cnt_next   = cnt_reg + 16'd1;
                pend_next  = s_ideal_glue;
                latch_next = s_break_cost > max_pen_reg;
                if (join_box) begin
                    used_next   = sum34[33:32] != 2'b00 ? 32'hFFFFFFFF : sum34[31:0];
                    fill_next   = fill_reg + 1'b1;
                    sum_st_next = sum_st_reg + TW'(prev_st_reg);
                    sum_sh_next = sum_sh_reg + TW'(prev_sh_reg);
                end else begin
                    used_next   = s_box_width;
                    fill_next   = FILL_W'(1);
                    sum_st_next = '0;
                    sum_sh_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            pend_reg   <= '0;
            latch_reg  <= 1'b0;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            bank_reg   <= 1'b0;
            busy_reg   <= '0;
            sum_st_reg <= '0;
            sum_sh_reg <= '0;
        end else begin
            used_reg   <= used_next;
            pend_reg   <= pend_next;
            latch_reg  <= latch_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            bank_reg   <= bank_next;
            busy_reg   <= busy_next;
            sum_st_reg <= sum_st_next;
            sum_sh_reg <= sum_sh_next;
        end
    end

    // weights of the newest box join the totals once a successor arrives
    always_ff @(posedge aclk) begin
        if (acc && !s_mode) begin
            prev_st_reg <= s_stretch_weight;
            prev_sh_reg <= s_shrink_weight;
        end
    end

    `ASSERT_IMP(a_fill_max, aclk, aresetn, 1'b1, fill_reg <= FILL_W'(MAX_LINE_BOXES))
    `ASSERT_IMP(a_push_free, aclk, aresetn, cmd_push, !busy_reg[~bank_reg] && !cmd_full)
    `ASSERT_IMP(a_empty_sums, aclk, aresetn, fill_reg == '0,
                sum_st_reg == '0 && sum_sh_reg == '0)

endmodule

@@ design/glj_back.sv @@
// Back: reads a buffered line and sets the glue of each box.
`include "assert_macros.svh"
module glj_back import glj_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  memwr_t       mem_wr,
    input  cmd_t         cmd_in,
    input  logic         cmd_empty,
    output logic         cmd_pop,
    output done_t        done,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [15:0]  m_box_position,
    output logic signed [31:0] m_glue_after,
    output logic signed [31:0] m_pad_before,
    output logic         m_broke_after,
    output logic signed [31:0] m_box_penalty,
    output logic         m_line_end
);

    logic [MEM_W-1:0]   buf_mem [2*MAX_LINE_BOXES];
    logic [MEM_W-1:0]   rd_reg;

    bstate_t            state_reg, state_next;
    cmd_t               cmd_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic [47:0]        prod_reg;
    logic [DW-1:0]      quo_reg;
    logic [TW+1:0]      rem_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic               m_valid_reg;

    logic               last, expanding, need_div, dstep_done;
    logic [31:0]        mag;
    logic [15:0]        wsel;
    logic [DW-1:0]      num;
    logic [TW+1:0]      rem_sh, dvs;
    logic               qbit;
    logic signed [33:0] half;
    logic signed [35:0] glue, pad, pen;
    logic               ld_cmd, adv;

    // line buffer, two banks
    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            buf_mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_reg <= buf_mem[{cmd_reg.bank, idx_reg[SLOT_W-1:0]}];
    end

    // per-box decode
    always_comb begin
        last      = (idx_reg == cmd_reg.fill - 1'b1);
        expanding = !cmd_reg.leftover[32];
        mag       = expanding ? cmd_reg.leftover[31:0] : 32'(-cmd_reg.leftover);
        wsel      = expanding ? rd_reg[15:0] : rd_reg[31:16];
        need_div  = (cmd_reg.kind == K_JUST) && !last && (cmd_reg.total != '0);
        num       = {1'b0, prod_reg, 1'b0} + DW'(cmd_reg.total);
        dvs       = {1'b0, cmd_reg.total, 1'b0};
        rem_sh    = {rem_reg[TW:0], num[DCW'(DW - 1) - dcnt_reg]};
        qbit      = rem_sh >= dvs;
        dstep_done = (dcnt_reg == DCW'(DW - 1));
    end

    // final glue, padding and penalty
    always_comb begin
        half = ($signed({cmd_reg.leftover[32], cmd_reg.leftover})
                + $signed({33'd0, cmd_reg.leftover[32]})) >>> 1;
        glue = last ? 36'sd0 : $signed({4'd0, rd_reg[63:32]});
        pad  = 36'sd0;
        if (cmd_reg.kind == K_JUST && !last) begin
            glue = expanding ? glue + $signed({3'd0, quo_reg[32:0]})
                             : glue - $signed({3'd0, quo_reg[32:0]});
        end
        if (cmd_reg.kind == K_CENTRE) begin
            if (idx_reg == '0) begin
                pad = 36'(half);
            end
            if (last) begin
                glue = glue + 36'(half);
            end
        end
        if (cmd_reg.kind == K_LEFT && last) begin
            glue = glue + 36'(cmd_reg.leftover);
        end
        if (!last) begin
            pen = 36'($signed(rd_reg[95:64]));
        end else if (cmd_reg.broke) begin
            pen = 36'($signed(rd_reg[95:64])) + $signed({4'd0, mag});
        end else begin
            pen = 36'sd0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!cmd_empty) state_next = B_READ;
            B_READ: state_next = B_MUL;
            B_MUL:  state_next = need_div ? B_DIV : B_FIN;
            B_DIV:  if (dstep_done) state_next = B_FIN;
            B_FIN:  state_next = B_OUT;
            B_OUT: begin
                if (m_ready) begin
                    state_next = last ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ld_cmd     = (state_reg == B_IDLE) && !cmd_empty;
        cmd_pop    = ld_cmd;
        adv        = (state_reg == B_OUT) && m_ready;
        done.valid = adv && last;
        done.bank  = cmd_reg.bank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (adv) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: multiply, then restoring divide one bit a cycle
    always_ff @(posedge aclk) begin
        if (ld_cmd) begin
            cmd_reg <= cmd_in;
            idx_reg <= '0;
        end else if (adv) begin
            idx_reg <= idx_reg + 1'b1;
        end
        unique case (state_reg)
            B_MUL: begin
                prod_reg <= 48'(mag) * 48'(wsel);
                quo_reg  <= '0;
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            B_DIV: begin
                quo_reg  <= {quo_reg[DW-2:0], qbit};
                rem_reg  <= qbit ? rem_sh - dvs : rem_sh;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            B_FIN: begin
                m_box_position <= rd_reg[111:96];
                m_glue_after   <= sat32(glue);
                m_pad_before   <= sat32(pad);
                m_box_penalty  <= sat32(pen);
                m_broke_after  <= last && cmd_reg.broke;
                m_line_end     <= last;
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

    `ASSERT_IMP(a_valid_state, aclk, aresetn, m_valid_reg, state_reg == B_OUT)
    `ASSERT_IMP(a_div_kind, aclk, aresetn, state_reg == B_DIV,
                cmd_reg.kind == K_JUST && cmd_reg.total != '0)
    `ASSERT_NXT(a_done_idle, aclk, aresetn, done.valid, state_reg == B_IDLE)

endmodule

@@ sim/tb_greedy_line_breaker_justify_top.sv @@
// Self-checking testbench for the greedy line breaker with justification.
`timescale 1ns / 100ps
module tb_greedy_line_breaker_justify_top;
    import glj_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 2000;

    typedef struct {
        bit [15:0]        pos;
        bit signed [31:0] glue;
        bit signed [31:0] pad;
        bit               broke;
        bit signed [31:0] pen;
        bit               lend;
    } box_out_t;

    typedef struct {
        bit               mode;
        bit [31:0]        bw;
        bit [31:0]        glue;
        bit [15:0]        sw;
        bit [15:0]        shw;
        bit signed [31:0] bc;
        bit               has_exp;
        box_out_t         res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_mode = 1'b0;
    logic [31:0] s_box_width = '0;
    logic [31:0] s_ideal_glue = '0;
    logic [15:0] s_stretch_weight = '0;
    logic [15:0] s_shrink_weight = '0;
    logic signed [31:0] s_break_cost = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_box_position;
    logic signed [31:0] m_glue_after;
    logic signed [31:0] m_pad_before;
    logic m_broke_after;
    logic signed [31:0] m_box_penalty;
    logic m_line_end;

    greedy_line_breaker_justify_top dut (.*);

    always #4 aclk = ~aclk;

    // line breaker state as seen from outside
    bit [31:0]        lb_width_cfg;
    bit signed [31:0] lb_max_pen;
    bit [1:0]         lb_jmode;
    bit [31:0]        ln_width [MAX_LINE_BOXES];
    bit [15:0]        ln_stretch [MAX_LINE_BOXES];
    bit [15:0]        ln_shrink [MAX_LINE_BOXES];
    bit [31:0]        ln_glue [MAX_LINE_BOXES];
    bit signed [31:0] ln_pen [MAX_LINE_BOXES];
    bit [15:0]        ln_pos [MAX_LINE_BOXES];
    bit [31:0]        used_w;
    bit [31:0]        glue_pending;
    bit               hold_break;
    int               fill;
    bit [15:0]        box_seq;

    box_out_t placed_q[$];
    bit  idle_on = 1'b1;
    bit  failed = 1'b0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  lines_seen = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // set the glue of the buffered line and queue one word per box
    function automatic void set_line(kind_t kind, bit broke);
        longint leftover = longint'(lb_width_cfg) - longint'(used_w);
        bit expanding = leftover >= 0;
        longint unsigned mag = expanding ? leftover : -leftover;
        longint unsigned total = 0;
        longint unsigned w;
        longint unsigned q;
        longint half = leftover / 2;
        longint g;
        longint p;
        longint pn;
        bit last;
        box_out_t r;
        if (fill == 0) return;
        for (int i = 0; i + 1 < fill; i++)
            total += expanding ? ln_stretch[i] : ln_shrink[i];
        for (int i = 0; i < fill; i++) begin
            last = (i + 1 == fill);
            g = last ? 0 : longint'(ln_glue[i]);
            p = 0;
            if (kind == K_JUST && !last && total != 0) begin
                w = expanding ? ln_stretch[i] : ln_shrink[i];
                q = (mag * w * 2 + total) / (2 * total);
                g = expanding ? g + longint'(q) : g - longint'(q);
            end
            if (kind == K_CENTRE) begin
                if (i == 0) p = half;
                if (last) g += half;
            end
            if (kind == K_LEFT && last) g += leftover;
            if (!last) pn = ln_pen[i];
            else if (broke) pn = clamp32(longint'(ln_pen[i]) + longint'(mag));
            else pn = 0;
            r.pos = ln_pos[i];
            r.glue = clamp32(g);
            r.pad = clamp32(p);
            r.broke = last && broke;
            r.pen = pn;
            r.lend = last;
            placed_q.insert(placed_q.size(), r);
        end
        fill = 0;
    endfunction

    function automatic void open_box(int slot, bit [31:0] bw, bit [31:0] gl,
                                     bit [15:0] sw, bit [15:0] shw, bit signed [31:0] bc);
        ln_width[slot] = bw;
        ln_stretch[slot] = sw;
        ln_shrink[slot] = shw;
        ln_glue[slot] = 0;
        ln_pen[slot] = bc;
        ln_pos[slot] = box_seq;
        hold_break = bc > lb_max_pen;
        glue_pending = gl;
        fill = slot + 1;
    endfunction

    // expected words for one accepted input word
    function automatic void place_word(bit mode, bit [31:0] bw, bit [31:0] gl,
                                       bit [15:0] sw, bit [15:0] shw, bit signed [31:0] bc);
        longint unsigned sum;
        if (mode) begin
            set_line(lb_jmode == JM_ALL ? K_JUST : (lb_jmode == JM_CENTRE ? K_CENTRE : K_LEFT),
                     1'b0);
            used_w = 0;
            glue_pending = 0;
            hold_break = 0;
            fill = 0;
            box_seq = 0;
            return;
        end
        sum = longint'(used_w) + longint'(glue_pending) + longint'(bw);
        if (fill == 0) begin
            open_box(0, bw, gl, sw, shw, bc);
            used_w = bw;
        end else if ((hold_break || sum <= lb_width_cfg) && fill < MAX_LINE_BOXES) begin
            ln_glue[fill - 1] = glue_pending;
            used_w = sum > 64'hFFFFFFFF ? 32'hFFFFFFFF : sum[31:0];
            open_box(fill, bw, gl, sw, shw, bc);
        end else begin
            set_line(lb_jmode <= JM_ALL ? K_JUST : (lb_jmode == JM_CENTRE ? K_CENTRE : K_LEFT),
                     1'b1);
            open_box(0, bw, gl, sw, shw, bc);
            used_w = bw;
        end
        box_seq = box_seq + 16'd1;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH: lb_width_cfg = val;
            CFG_MAX_PEN:    lb_max_pen = val;
            CFG_JMODE:      lb_jmode = val[1:0];
            default: ;
        endcase
    endtask

    // drive one word and wait for its acceptance
    task automatic send_word(bit mode, bit [31:0] bw, bit [31:0] gl,
                             bit [15:0] sw, bit [15:0] shw, bit signed [31:0] bc);
        if (idle_on && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_box_width <= bw;
        s_ideal_glue <= gl;
        s_stretch_weight <= sw;
        s_shrink_weight <= shw;
        s_break_cost <= bc;
        do @(posedge aclk); while (!s_ready);
        place_word(mode, bw, gl, sw, shw, bc);
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (placed_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // one random box, mostly of text-like size
    task automatic send_rand_box();
        bit [31:0] bw;
        bit [31:0] gl;
        bit [15:0] sw;
        bit [15:0] shw;
        bit signed [31:0] bc;
        bw = ($urandom_range(99) < 10) ? $urandom() : ($urandom_range(0, 20) << 16) + $urandom_range(0, 65535);
        gl = ($urandom_range(99) < 10) ? $urandom() : ($urandom_range(0, 3) << 16) + $urandom_range(0, 65535);
        sw = ($urandom_range(99) < 20) ? 16'd0 : 16'($urandom());
        shw = ($urandom_range(99) < 20) ? 16'd0 : 16'($urandom());
        case ($urandom_range(9))
            0: bc = $urandom();
            1: bc = 32'sh7FFFFFFF;
            default: bc = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
        endcase
        send_word(1'b0, bw, gl, sw, shw, bc);
    endtask

    // result side: random stalls and field checks
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin
        box_out_t e;
        if (aresetn && m_valid && m_ready) begin
            if (placed_q.size() == 0) begin
                $error("unexpected word: position %0d", m_box_position);
                failed = 1'b1;
            end else begin
                e = placed_q.pop_front();
                if (m_box_position !== e.pos) begin
                    $error("box_position: expected %0d, got %0d", e.pos, m_box_position);
                    failed = 1'b1;
                end
                if (m_glue_after !== e.glue) begin
                    $error("glue_after: expected %0d, got %0d", e.glue, m_glue_after);
                    failed = 1'b1;
                end
                if (m_pad_before !== e.pad) begin
                    $error("pad_before: expected %0d, got %0d", e.pad, m_pad_before);
                    failed = 1'b1;
                end
                if (m_broke_after !== e.broke) begin
                    $error("broke_after: expected %0d, got %0d", e.broke, m_broke_after);
                    failed = 1'b1;
                end
                if (m_box_penalty !== e.pen) begin
                    $error("box_penalty: expected %0d, got %0d", e.pen, m_box_penalty);
                    failed = 1'b1;
                end
                if (m_line_end !== e.lend) begin
                    $error("line_end: expected %0d, got %0d", e.lend, m_line_end);
                    failed = 1'b1;
                end
                words_checked++;
                if (e.lend) lines_seen++;
            end
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_greedy_line_breaker_justify_top: errors");
            $finish;
        end
    end

    stim_row_t rows[$];
    bit [31:0] widths[5] = '{32'd0, 32'hFFFFFFFF, 32'd60 << 16, 32'd100 << 16, 32'd25 << 16};
    bit [31:0] pens[3] = '{32'h7FFFFFFF, 32'h80000000, 32'h00100000};

    // append one directed row
    function automatic void add_row(stim_row_t row);
        rows.insert(rows.size(), row);
    endfunction

    initial begin
        stim_row_t r;
        int plen;
        // predictor reset
        lb_width_cfg = 0;
        lb_max_pen = 0;
        lb_jmode = JM_FULL;
        used_w = 0;
        glue_pending = 0;
        hold_break = 0;
        fill = 0;
        box_seq = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset settings: zero width, full mode
        add_row('{0, 32'h00010000, 0, 16'h0100, 16'h0100, 0, 0, '{0, 0, 0, 0, 0, 0}});
        add_row('{0, 32'h00020000, 0, 0, 0, 32'sh10, 1,
                  '{16'd0, 32'sd0, 32'sd0, 1'b1, 32'sh00010000, 1'b1}});
        add_row('{1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, -1, 1,
                  '{16'd1, -32'sh00020000, 32'sd0, 1'b0, 32'sd0, 1'b1}});
        // break forbidden, overlong boxes, saturating width and penalty
        add_row('{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 0,
                  '{0, 0, 0, 0, 0, 0}});
        add_row('{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 32'sh7FFFFFFF, 0,
                  '{0, 0, 0, 0, 0, 0}});
        add_row('{0, 32'h0, 32'h0, 16'h0, 16'hFFFF, -32'sh7FFFFFFF - 1, 0,
                  '{0, 0, 0, 0, 0, 0}});
        add_row('{0, 32'h00010000, 32'h00010000, 16'h0, 16'h0, 0, 0, '{0, 0, 0, 0, 0, 0}});
        // flush, then flush of an empty line
        add_row('{1, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
        add_row('{1, 0, 0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
        foreach (rows[i]) begin
            r = rows[i];
            send_word(r.mode, r.bw, r.glue, r.sw, r.shw, r.bc);
            if (r.has_exp && placed_q.size() > 0) placed_q[$] = r.res;
        end
        drain();

        // out-of-range index is ignored
        write_reg(2'd3, 32'hFFFFFFFF);

        // random paragraphs over a sweep of settings
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(CFG_LINE_WIDTH, (ph == 8) ? $urandom() : widths[ph % 5]);
            write_reg(CFG_MAX_PEN, pens[ph % 3]);
            write_reg(CFG_JMODE, 2'(ph % 4));
            for (int n = 0; n < 38; ) begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(33, 45) : $urandom_range(1, 14);
                for (int k = 0; k < plen; k++) send_rand_box();
                send_word(1'b1, $urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
                          $urandom());
                n += plen + 1;
            end
            drain();
        end

        // one paragraph that overfills the line buffer, no idling
        idle_on = 1'b0;
        write_reg(CFG_LINE_WIDTH, 32'hFFFFFFFF);
        write_reg(CFG_MAX_PEN, 32'h0);
        write_reg(CFG_JMODE, JM_LEFT);
        for (int k = 0; k < 50; k++)
            send_word(1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 32'sh0);
        send_word(1'b1, 0, 0, 0, 0, 0);
        drain();

        $display("Sent %0d input words; checked %0d boxes on %0d lines.",
                 words_sent, words_checked, lines_seen);
        $display("Covered all four justify modes, width and penalty extremes, full line buffer.");
        if (!failed && placed_q.size() == 0) begin
            $display("tb_greedy_line_breaker_justify_top: clean");
        end else begin
            $display("tb_greedy_line_breaker_justify_top: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/glj_pkg.sv
design/glj_cmd_fifo.sv
design/glj_front.sv
design/glj_back.sv
design/greedy_line_breaker_justify_top.sv
sim/tb_greedy_line_breaker_justify_top.sv
